FILE: sv/assert_macros.svh
// Assertion helper macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is low.
`define ASSERT_IMPLIES(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");

// Next-cycle implication, quiet while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");

`endif

FILE: sv/itmtpd_pkg.sv
// ----------------------------------------------------------------------------
// itmtpd_pkg
// Shared types and constants for the trace packet decoder.
// ----------------------------------------------------------------------------
package itmtpd_pkg;

	localparam int MAX_PACKET_BYTES_DEF = 8;
	localparam logic [7:0] GAP_FACTOR_RST = 8'd16;

	// Result kinds
	localparam logic [3:0] KIND_OVERFLOW = 4'd0;
	localparam logic [3:0] KIND_SYNC     = 4'd1;
	localparam logic [3:0] KIND_TSTAMP   = 4'd2;
	localparam logic [3:0] KIND_SW       = 4'd3;
	localparam logic [3:0] KIND_DWT_EVT  = 4'd4;
	localparam logic [3:0] KIND_EXC      = 4'd5;
	localparam logic [3:0] KIND_PC       = 4'd6;
	localparam logic [3:0] KIND_WATCH    = 4'd7;
	localparam logic [3:0] KIND_OTHER_HW = 4'd8;
	localparam logic [3:0] KIND_EXT      = 4'd9;
	localparam logic [3:0] KIND_MODE     = 4'd10;

	// Header codes
	localparam logic [7:0] HDR_OVERFLOW  = 8'h70;
	localparam logic [7:0] MASK_SYNC     = 8'h7F;
	localparam logic [7:0] MASK_WATCH    = 8'hC4;
	localparam logic [7:0] CODE_WATCH    = 8'h84;
	localparam logic [3:0] LOW_EXT_A     = 4'h4;
	localparam logic [3:0] LOW_EXT_B     = 4'h8;
	localparam logic [3:0] LOW_EXT_C     = 4'hC;
	localparam logic [7:0] SYNC_TAIL     = 8'h80;
	localparam logic [47:0] SYNC_PATTERN = 48'h0000_0000_0080;
	localparam logic [2:0] SYNC_BYTES    = 3'd6;

	// Exception event codes
	localparam logic [3:0] EV_ENTER  = 4'd1;
	localparam logic [3:0] EV_EXIT   = 4'd2;
	localparam logic [3:0] EV_RESUME = 4'd3;

	typedef struct packed {
		logic [3:0]  kind;
		logic [4:0]  port_id;
		logic [7:0]  header;
		logic [31:0] payload;
		logic [3:0]  packet_length;
		logic [3:0]  detail;
		logic [63:0] time_total;
		logic [47:0] span_begin;
		logic [47:0] span_finish;
		logic        last;
	} res_t;

	// Payload size from the low header bits
	function automatic logic [2:0] len_code(input logic [1:0] c);
		logic [2:0] r;
		unique case (c)
			2'd0: r = 3'd0;
			2'd1: r = 3'd1;
			2'd2: r = 3'd2;
			default: r = 3'd4;
		endcase
		return r;
	endfunction

endpackage

FILE: sv/itm_trace_packet_decoder_top.sv
// ----------------------------------------------------------------------------
// itm_trace_packet_decoder_top
// Trace byte framer and packet classifier with timestamp and mode tracking.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one trace byte per beat with its
//   start and end sample times. Output channel (out_valid/out_ready) carries
//   one decoded result per beat; a byte yields zero, one or two results, the
//   final one flagged by last.
//   gap_factor is written through cfg_wr_en/cfg_wr_data; the user must do so
//   only while the block idles, as the block itself does not enforce this.
// Path: a byte is registered on accept and decoded from the input register
//   once the queue has room; its results are written into a four-entry
//   output queue, whose head drives the result outputs.
// Throughput: one byte per cycle while the queue has room for two results,
//   as the decode stage advances only then, so the queue depth sets how long
//   the block keeps accepting under a stalled receiver.
// Reset: arst_n clears the packet framing, sync window, timestamp sum, mode
//   tracking and the queue; gap_factor returns to 16.
// Stall: results wait in the queue unchanged; once it holds three or more and
//   a byte waits in the input register, in_ready drops.
// ----------------------------------------------------------------------------
module itm_trace_packet_decoder_top #(
	parameter int MAX_PACKET_BYTES = itmtpd_pkg::MAX_PACKET_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  byte_value,
	input  logic [47:0] start_time,
	input  logic [47:0] end_time,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  kind,
	output logic [4:0]  port_id,
	output logic [7:0]  header,
	output logic [31:0] payload,
	output logic [3:0]  packet_length,
	output logic [3:0]  detail,
	output logic [63:0] time_total,
	output logic [47:0] span_begin,
	output logic [47:0] span_finish,
	output logic        last
);
	import itmtpd_pkg::*;

	localparam int CW = $clog2(MAX_PACKET_BYTES + 1);
	localparam int IW = $clog2(MAX_PACKET_BYTES);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PACKET_BYTES);
	localparam int QD = 4;

	// Configuration
	logic [7:0] gap_factor_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_factor_q <= GAP_FACTOR_RST;
		end else if (cfg_wr_en) begin
			gap_factor_q <= cfg_wr_data;
		end
	end

	// Input stage
	logic        v_s1;
	logic [7:0]  byte_s1;
	logic [47:0] st_s1, en_s1, blen_s1, gap_s1;
	logic [47:0] prev_end_q;
	logic        proc_go;
	logic [2:0]  q_cnt_q;

	assign proc_go  = v_s1 && (q_cnt_q <= 3'(QD - 2));
	assign in_ready = !v_s1 || proc_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			prev_end_q <= '0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
			if (in_valid) begin
				prev_end_q <= end_time;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= byte_value;
			st_s1   <= start_time;
			en_s1   <= end_time;
			blen_s1 <= end_time - start_time;
			gap_s1  <= start_time - prev_end_q;
		end
	end

	// Framing state
	logic [7:0]    pkt_q [MAX_PACKET_BYTES];
	logic [CW-1:0] pkt_cnt_q;
	logic [47:0]   pkt_start_q;
	logic [47:0]   win_q;
	logic [2:0]    fill_q;
	logic [63:0]   ts_sum_q;
	logic          mode_act_q;
	logic [47:0]   mode_start_q;

	// Gap check and byte capture
	logic [55:0]   prod;
	logic          gap_hit, hold;
	logic [CW-1:0] cnt_base, cnt_new, pcnt;
	logic [47:0]   start_new, win_new;
	logic [2:0]    fill_new;
	logic          force_sync;
	logic [7:0]    pd [MAX_PACKET_BYTES];

	always_comb begin
		prod      = 56'(gap_factor_q) * 56'(blen_s1);
		gap_hit   = {8'd0, gap_s1} > prod;
		cnt_base  = gap_hit ? '0 : pkt_cnt_q;
		hold      = cnt_base < CNT_MAX;
		cnt_new   = hold ? cnt_base + 1'b1 : cnt_base;
		start_new = (hold && cnt_base == '0) ? st_s1 : pkt_start_q;
		win_new   = {win_q[39:0], byte_s1};
		fill_new  = (fill_q < SYNC_BYTES) ? fill_q + 3'd1 : fill_q;
		force_sync = (fill_new == SYNC_BYTES) && (win_new == SYNC_PATTERN);
		for (int i = 0; i < MAX_PACKET_BYTES; i++) begin
			if (force_sync && i < 5) begin
				pd[i] = 8'd0;
			end else if (force_sync && i == 5) begin
				pd[i] = SYNC_TAIL;
			end else if (hold && cnt_base == CW'(i)) begin
				pd[i] = byte_s1;
			end else begin
				pd[i] = pkt_q[i];
			end
		end
		pcnt = force_sync ? CW'(SYNC_BYTES) : cnt_new;
	end

	// Completion check and classification
	logic [7:0]  h;
	logic [3:0]  low;
	logic [4:0]  port;
	logic [2:0]  plen;
	logic        cont_end, complete, done;
	logic [27:0] ts_long;
	logic [31:0] ts_val, le;
	logic [3:0]  ev;
	logic        span_emit, mode_clr, mode_set;
	res_t        main_r, span_r;

	always_comb begin
		h    = pd[0];
		low  = h[3:0];
		port = h[7:3];
		plen = len_code(h[1:0]);
		cont_end = 1'b0;
		for (int i = 1; i < MAX_PACKET_BYTES; i++) begin
			if (CW'(i) < pcnt && !pd[i][7]) begin
				cont_end = 1'b1;
			end
		end
		priority if ((h & MASK_SYNC) == 8'd0 || h == HDR_OVERFLOW) begin
			complete = 1'b1;
		end else if (low == 4'd0) begin
			complete = !h[7] || cont_end;
		end else if (low == LOW_EXT_A || low == LOW_EXT_B || low == LOW_EXT_C) begin
			complete = 1'b1;
		end else begin
			complete = pcnt >= CW'(plen) + 1'b1;
		end
		done = force_sync || (pcnt != '0 && complete);

		// Timestamp continuation bytes
		ts_long = '0;
		for (int i = 1; i <= 4; i++) begin
			if (CW'(i) < pcnt) begin
				ts_long[7*(i-1) +: 7] = pd[i][6:0];
			end
		end
		ts_val = h[7] ? {4'd0, ts_long} : {29'd0, h[6:4]};

		// Little-endian payload bytes
		le = '0;
		for (int i = 0; i < 4; i++) begin
			if (3'(i) < plen && CW'(i + 1) < pcnt) begin
				le[8*i +: 8] = pd[i + 1];
			end
		end

		ev        = pd[2][7:4];
		span_emit = 1'b0;
		mode_clr  = 1'b0;
		mode_set  = 1'b0;

		main_r.port_id       = port;
		main_r.header        = h;
		main_r.payload       = '0;
		main_r.packet_length = 4'(pcnt);
		main_r.detail        = '0;
		main_r.time_total    = ts_sum_q;
		main_r.span_begin    = start_new;
		main_r.span_finish   = en_s1;
		main_r.last          = 1'b1;

		priority if ((h & MASK_SYNC) == 8'd0) begin
			main_r.kind = KIND_SYNC;
		end else if (h == HDR_OVERFLOW) begin
			main_r.kind = KIND_OVERFLOW;
		end else if (low == 4'd0) begin
			main_r.kind       = KIND_TSTAMP;
			main_r.detail     = h[7] ? {2'd0, h[5:4]} : 4'd0;
			main_r.payload    = ts_val;
			main_r.time_total = ts_sum_q + 64'(ts_val);
		end else if (low == LOW_EXT_A || low == LOW_EXT_B || low == LOW_EXT_C) begin
			main_r.kind = KIND_EXT;
		end else if (!h[2]) begin
			main_r.kind    = KIND_SW;
			main_r.payload = le;
		end else if (port == 5'd0) begin
			main_r.kind    = KIND_DWT_EVT;
			main_r.payload = {24'd0, pd[1]};
		end else if (port == 5'd1 && plen >= 3'd2) begin
			main_r.kind    = KIND_EXC;
			main_r.payload = {23'd0, pd[2][0], pd[1]};
			main_r.detail  = ev;
			if (ev == EV_ENTER || ev == EV_EXIT || ev == EV_RESUME) begin
				span_emit = mode_act_q;
				mode_clr  = (ev == EV_EXIT);
				mode_set  = (ev != EV_EXIT);
			end
		end else if (port == 5'd2 && plen == 3'd4) begin
			main_r.kind    = KIND_PC;
			main_r.payload = le;
		end else if ((h & MASK_WATCH) == CODE_WATCH) begin
			main_r.kind    = KIND_WATCH;
			main_r.port_id = {3'd0, h[5:4]};
			main_r.detail  = {3'd0, h[3]};
			main_r.payload = le;
		end else begin
			main_r.kind    = KIND_OTHER_HW;
			main_r.payload = le;
		end

		span_r.kind          = KIND_MODE;
		span_r.port_id       = '0;
		span_r.header        = '0;
		span_r.payload       = '0;
		span_r.packet_length = '0;
		span_r.detail        = '0;
		span_r.time_total    = ts_sum_q;
		span_r.span_begin    = mode_start_q;
		span_r.span_finish   = st_s1;
		span_r.last          = 1'b0;
	end

	// Advance framing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_cnt_q    <= '0;
			pkt_start_q  <= '0;
			win_q        <= '0;
			fill_q       <= '0;
			ts_sum_q     <= '0;
			mode_act_q   <= 1'b0;
			mode_start_q <= '0;
		end else if (proc_go) begin
			pkt_cnt_q   <= done ? '0 : cnt_new;
			pkt_start_q <= start_new;
			win_q       <= win_new;
			fill_q      <= fill_new;
			if (done) begin
				ts_sum_q <= main_r.time_total;
				if (mode_clr) begin
					mode_act_q <= 1'b0;
				end else if (mode_set) begin
					mode_act_q   <= 1'b1;
					mode_start_q <= st_s1;
				end
			end
		end
	end

	// Packet byte store
	always_ff @(posedge clk) begin
		if (proc_go && hold) begin
			pkt_q[cnt_base[IW-1:0]] <= byte_s1;
		end
	end

	// Output queue
	res_t       q_mem [QD];
	logic [1:0] wr_ptr_q, rd_ptr_q;
	logic [1:0] push_n;
	logic       pop;

	assign push_n = (proc_go && done) ? (span_emit ? 2'd2 : 2'd1) : 2'd0;
	assign pop    = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			q_cnt_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_n;
			rd_ptr_q <= rd_ptr_q + {1'b0, pop};
			q_cnt_q  <= q_cnt_q + {1'b0, push_n} - {2'd0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push_n == 2'd2) begin
			q_mem[wr_ptr_q]        <= span_r;
			q_mem[wr_ptr_q + 2'd1] <= main_r;
		end else if (push_n == 2'd1) begin
			q_mem[wr_ptr_q] <= main_r;
		end
	end

	assign out_valid     = q_cnt_q != 3'd0;
	assign kind          = q_mem[rd_ptr_q].kind;
	assign port_id       = q_mem[rd_ptr_q].port_id;
	assign header        = q_mem[rd_ptr_q].header;
	assign payload       = q_mem[rd_ptr_q].payload;
	assign packet_length = q_mem[rd_ptr_q].packet_length;
	assign detail        = q_mem[rd_ptr_q].detail;
	assign time_total    = q_mem[rd_ptr_q].time_total;
	assign span_begin    = q_mem[rd_ptr_q].span_begin;
	assign span_finish   = q_mem[rd_ptr_q].span_finish;
	assign last          = q_mem[rd_ptr_q].last;

endmodule

FILE: sv/itmtpd_checker.sv
// ----------------------------------------------------------------------------
// itmtpd_checker
// Port-level checks on the decoder's result channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module itmtpd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [3:0] kind,
	input logic [7:0] header,
	input logic [3:0] packet_length,
	input logic       last
);
	import itmtpd_pkg::*;

	// Hold a stalled result beat
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(kind))
	// A mode span is never final and carries no packet bytes
	`ASSERT_IMPLIES(a_span_fields, clk, arst_n, out_valid && kind == KIND_MODE, !last && header == 8'd0 && packet_length == 4'd0)
	// A mode span is followed at once by its exception beat
	`ASSERT_NEXT(a_span_then_exc, clk, arst_n, out_valid && out_ready && kind == KIND_MODE, out_valid && kind == KIND_EXC && last)

endmodule

bind itm_trace_packet_decoder_top itmtpd_checker u_itmtpd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.kind          (kind),
	.header        (header),
	.packet_length (packet_length),
	.last          (last)
);
